/* hdl/cssim_pkg.sv */
// Shared types, constants and helpers of the cell SSIM engine.
package cssim_pkg;

   localparam int MAX_CELL_DIM = 16;
   localparam int STORE_DEPTH  = MAX_CELL_DIM * MAX_CELL_DIM;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int COUNT_W      = $clog2(STORE_DEPTH + 1);
   localparam int DIM_W        = 5;
   localparam int SUM_W        = 16;
   localparam int DIVD_W       = 25;

   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_CELL_DIM);
   localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(1);

   localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
   localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;

   localparam logic [14:0] SCALE2    = 15'd20000;
   localparam logic [13:0] SCALE     = 14'd10000;
   localparam logic [16:0] C1_SCALED = 17'd65025;
   localparam logic [19:0] C2_SCALED = 20'd585225;
   localparam logic [16:0] Q16_ONE   = 17'd65536;

   typedef struct packed {
      logic [SUM_W-1:0]   sum_a;
      logic [SUM_W-1:0]   sum_b;
      logic [COUNT_W-1:0] n;
   } job_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_req_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MA, ST_MB, ST_PASS, ST_VA, ST_VB, ST_COV,
      ST_MUL1, ST_MUL2, ST_MUL3, ST_QINIT, ST_QSTEP, ST_OUT
   } back_state_type;

   // floor(s/3) for s up to 765 by reciprocal multiply
   function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      logic [9:0]  s;
      logic [19:0] p;
      s = {2'b00, r} + {2'b00, g} + {2'b00, b};
      p = s * 10'd683;
      return p[18:11];
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      if (d < DIM_MIN) return DIM_MIN;
      if (d > DIM_MAX) return DIM_MAX;
      return d;
   endfunction

endpackage

/* hdl/cssim_if.sv */
// Channel interfaces: pixel pair requests and SSIM responses.
interface cssim_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_a;
   logic [7:0] green_a;
   logic [7:0] blue_a;
   logic [7:0] red_b;
   logic [7:0] green_b;
   logic [7:0] blue_b;
   modport source (output valid, red_a, green_a, blue_a, red_b, green_b, blue_b,
                   input ready);
   modport sink   (input valid, red_a, green_a, blue_a, red_b, green_b, blue_b,
                   output ready);
endinterface

interface cssim_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] ssim_q16;
   logic [7:0]         mean_a;
   logic [7:0]         mean_b;
   logic [13:0]        variance_a;
   logic [13:0]        variance_b;
   logic signed [14:0] covariance_ab;
   modport source (output valid, ssim_q16, mean_a, mean_b, variance_a, variance_b,
                   covariance_ab, input ready);
   modport sink   (input valid, ssim_q16, mean_a, mean_b, variance_a, variance_b,
                   covariance_ab, output ready);
endinterface

/* hdl/cell_ssim_engine.sv */
// Top level of the cell SSIM engine.
// Usage: set cell_width (index 0) and cell_height (index 1) through the csr_
// write port while idle; each write restarts the current cell. Values of 0
// act as 1, values above 16 act as 16. Stream n = width*height pixel pairs on
// req, one transaction per cycle, in raster order. The transaction that
// completes a cell produces one rsp transaction with SSIM in Q1.16, both
// means, both variances and the covariance; earlier ones produce nothing.
// After the last pixel is accepted, the back end picks up the job, runs two
// divisions by n in the shared divider for the means, one sweep of the pixel
// store, three divisions for the variances and covariance, three multiply
// stages and a Q16 division, then loads the output register for rsp valid.
// Flow control: req is held off from the end of a cell until the sweep of the
// pixel store is over, and a busy back end adds its remaining time to the
// hold-off.
// The next cell loads while the back end finishes the previous one.
// Reset (synchronous) restores 8x8 and clears counts and sums; the pixel
// store is not cleared. A stalled rsp holds its result and stops the back end
// at its output register only.
module cell_ssim_engine
   import cssim_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   cssim_req_if.sink        req,
   cssim_rsp_if.source      rsp,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [DIM_W-1:0] csr_data
);
   job_type    push_job, head_job;
   logic       push, full, pop, empty, rel;
   rd_req_type rd_req;
   logic [15:0] rd_data;

   cssim_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .job_push      (push),
      .job           (push_job),
      .job_full      (full),
      .release_store (rel),
      .rd_req        (rd_req),
      .rd_data       (rd_data)
   );

   cssim_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head_job)
   );

   cssim_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_empty     (empty),
      .job_head      (head_job),
      .job_pop       (pop),
      .rd_req        (rd_req),
      .rd_data       (rd_data),
      .release_store (rel),
      .rsp           (rsp)
   );
endmodule

/* hdl/cssim_div.sv */
// Restoring divider, one quotient bit per cycle.
module cssim_div
   import cssim_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [COUNT_W-1:0]  rem_ff;
   logic [DIVD_W-1:0]   quo_ff;
   logic [COUNT_W-1:0]  den_ff;
   logic [COUNT_W:0]    trial;
   logic                take;

   assign trial = {rem_ff, quo_ff[DIVD_W-1]};
   assign take  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= take ? COUNT_W'(trial - {1'b0, den_ff}) : COUNT_W'(trial);
         quo_ff <= {quo_ff[DIVD_W-2:0], take};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* hdl/cssim_queue.sv */
// Two-entry job queue between front and back.
module cssim_queue
   import cssim_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head
);
   job_type    slot_ff [2];
   logic       wptr_ff;
   logic       rptr_ff;
   logic [1:0] fill_ff;

   assign full  = fill_ff == 2'd2;
   assign empty = fill_ff == 2'd0;
   assign head  = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push && !full) wptr_ff <= ~wptr_ff;
         if (pop && !empty) rptr_ff <= ~rptr_ff;
         fill_ff <= fill_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) slot_ff[wptr_ff] <= push_data;
   end
endmodule

/* hdl/cssim_front.sv */
// Front end: configuration, gray conversion, pixel store and running sums.
module cssim_front
   import cssim_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   cssim_req_if.sink       req,
   input  logic            csr_write_en,
   input  logic [1:0]      csr_index,
   input  logic [DIM_W-1:0] csr_data,
   output logic            job_push,
   output job_type         job,
   input  logic            job_full,
   input  logic            release_store,
   input  rd_req_type      rd_req,
   output logic [15:0]     rd_data
);
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [SUM_W-1:0]   sum_a_ff;
   logic [SUM_W-1:0]   sum_b_ff;
   logic               pending_ff;
   logic [15:0]        mem [STORE_DEPTH];
   logic [15:0]        rd_data_ff;

   logic [COUNT_W-1:0] n;
   logic [7:0]         ga;
   logic [7:0]         gb;
   logic               accept;
   logic               last;
   logic [SUM_W-1:0]   sum_a_in;
   logic [SUM_W-1:0]   sum_b_in;
   logic               cfg_hit;

   assign n        = COUNT_W'(clamp_dim(width_ff)) * COUNT_W'(clamp_dim(height_ff));
   assign ga       = gray_of(req.red_a, req.green_a, req.blue_a);
   assign gb       = gray_of(req.red_b, req.green_b, req.blue_b);
   assign req.ready = !pending_ff && !job_full;
   assign accept   = req.valid && req.ready;
   assign last     = (count_ff + 1'b1) == n;
   assign sum_a_in = sum_a_ff + SUM_W'(ga);
   assign sum_b_in = sum_b_ff + SUM_W'(gb);
   assign cfg_hit  = csr_write_en &&
                     (csr_index == REG_CELL_WIDTH || csr_index == REG_CELL_HEIGHT);

   assign job_push  = accept && last;
   assign job.sum_a = sum_a_in;
   assign job.sum_b = sum_b_in;
   assign job.n     = n;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DIM_W'(8);
         height_ff  <= DIM_W'(8);
         count_ff   <= '0;
         sum_a_ff   <= '0;
         sum_b_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         if (csr_write_en && csr_index == REG_CELL_WIDTH)  width_ff  <= csr_data;
         if (csr_write_en && csr_index == REG_CELL_HEIGHT) height_ff <= csr_data;
         if (cfg_hit) begin
            count_ff <= '0;
            sum_a_ff <= '0;
            sum_b_ff <= '0;
         end else if (accept) begin
            if (last) begin
               count_ff <= '0;
               sum_a_ff <= '0;
               sum_b_ff <= '0;
            end else begin
               count_ff <= count_ff + 1'b1;
               sum_a_ff <= sum_a_in;
               sum_b_ff <= sum_b_in;
            end
         end
         // hold the store until the back end has swept it
         if (job_push)           pending_ff <= 1'b1;
         else if (release_store) pending_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) mem[count_ff[ADDR_W-1:0]] <= {ga, gb};
      if (rd_req.en) rd_data_ff <= mem[rd_req.addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/cssim_back.sv */
// Back end: means, variance and covariance sweep, SSIM products and Q16 division.
module cssim_back
   import cssim_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_empty,
   input  job_type     job_head,
   output logic        job_pop,
   output rd_req_type  rd_req,
   input  logic [15:0] rd_data,
   output logic        release_store,
   cssim_rsp_if.source rsp
);
   back_state_type     state_ff, state_in;

   logic [COUNT_W-1:0] n_ff;
   logic [SUM_W-1:0]   sum_b_ff;
   logic [7:0]         ma_ff, mb_ff;
   logic [COUNT_W-1:0] idx_ff;
   logic               rd_vld_ff;
   logic [DIVD_W-1:0]  sva_ff, svb_ff;
   logic signed [DIVD_W-1:0] scov_ff;
   logic [13:0]        va_ff, vb_ff;
   logic signed [14:0] cov_ff;
   logic [15:0]        pab_ff;
   logic [16:0]        sq_ff;
   logic [14:0]        vsum_ff;
   logic [30:0]        afac_ff, f1_ff;
   logic [28:0]        f2_ff;
   logic signed [29:0] bfac_ff;
   logic [59:0]        num_ff, den_ff, rem_ff;
   logic               neg_ff;
   logic               sat_ff;
   logic [16:0]        q_ff;
   logic [3:0]         step_ff;

   logic               out_vld_ff;
   logic signed [17:0] o_ssim_ff;
   logic [7:0]         o_ma_ff, o_mb_ff;
   logic [13:0]        o_va_ff, o_vb_ff;
   logic signed [14:0] o_cov_ff;

   logic               div_start;
   logic [DIVD_W-1:0]  div_num;
   logic [COUNT_W-1:0] div_den;
   logic               div_done;
   logic [DIVD_W-1:0]  div_q;
   logic               out_free;
   logic [DIVD_W-1:0]  scov_mag;

   logic signed [8:0]  da, db;
   logic [29:0]        bmag;
   logic [60:0]        trial;
   logic [16:0]        mag;

   cssim_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign out_free = !out_vld_ff || rsp.ready;
   assign scov_mag = scov_ff[DIVD_W-1] ? DIVD_W'(-scov_ff) : DIVD_W'(scov_ff);
   assign da       = $signed({1'b0, rd_data[15:8]}) - $signed({1'b0, ma_ff});
   assign db       = $signed({1'b0, rd_data[7:0]}) - $signed({1'b0, mb_ff});
   assign bmag     = bfac_ff[29] ? 30'(-bfac_ff) : 30'(bfac_ff);
   assign trial    = {rem_ff, 1'b0};
   assign mag      = (sat_ff || q_ff > Q16_ONE) ? Q16_ONE : q_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (!job_empty) state_in = ST_MA;
         ST_MA:    if (div_done) state_in = ST_MB;
         ST_MB:    if (div_done) state_in = ST_PASS;
         ST_PASS:  if (idx_ff == n_ff && !rd_vld_ff) state_in = ST_VA;
         ST_VA:    if (div_done) state_in = ST_VB;
         ST_VB:    if (div_done) state_in = ST_COV;
         ST_COV:   if (div_done) state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_MUL3;
         ST_MUL3:  state_in = ST_QINIT;
         ST_QINIT: state_in = ST_QSTEP;
         ST_QSTEP: if (step_ff == 4'd15) state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      job_pop       = 1'b0;
      div_start     = 1'b0;
      div_num       = '0;
      div_den       = n_ff;
      release_store = 1'b0;
      rd_req.en     = 1'b0;
      rd_req.addr   = idx_ff[ADDR_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            job_pop   = !job_empty;
            div_start = !job_empty;
            div_num   = DIVD_W'(job_head.sum_a);
            div_den   = job_head.n;
         end
         ST_MA: begin
            div_start = div_done;
            div_num   = DIVD_W'(sum_b_ff);
         end
         ST_PASS: begin
            rd_req.en = idx_ff != n_ff;
            if (idx_ff == n_ff && !rd_vld_ff) begin
               release_store = 1'b1;
               div_start     = 1'b1;
               div_num       = sva_ff;
            end
         end
         ST_VA: begin
            div_start = div_done;
            div_num   = svb_ff;
         end
         ST_VB: begin
            div_start = div_done;
            div_num   = scov_mag;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_req.en;
         if (state_ff == ST_OUT && out_free) out_vld_ff <= 1'b1;
         else if (rsp.ready)                 out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            n_ff     <= job_head.n;
            sum_b_ff <= job_head.sum_b;
         end
         ST_MA: if (div_done) ma_ff <= div_q[7:0];
         ST_MB: if (div_done) begin
            mb_ff   <= div_q[7:0];
            idx_ff  <= '0;
            sva_ff  <= '0;
            svb_ff  <= '0;
            scov_ff <= '0;
         end
         ST_PASS: begin
            if (rd_req.en) idx_ff <= idx_ff + 1'b1;
            if (rd_vld_ff) begin
               sva_ff  <= sva_ff + DIVD_W'($unsigned(16'(da * da)));
               svb_ff  <= svb_ff + DIVD_W'($unsigned(16'(db * db)));
               scov_ff <= scov_ff + DIVD_W'(18'(da * db));
            end
         end
         ST_VA:  if (div_done) va_ff <= div_q[13:0];
         ST_VB:  if (div_done) vb_ff <= div_q[13:0];
         ST_COV: if (div_done)
            cov_ff <= scov_ff[DIVD_W-1] ? -$signed(div_q[14:0]) : $signed(div_q[14:0]);
         ST_MUL1: begin
            pab_ff  <= ma_ff * mb_ff;
            sq_ff   <= 17'(ma_ff * ma_ff) + 17'(mb_ff * mb_ff);
            vsum_ff <= 15'(va_ff) + 15'(vb_ff);
         end
         ST_MUL2: begin
            afac_ff <= 31'(pab_ff * SCALE2) + 31'(C1_SCALED);
            f1_ff   <= 31'(sq_ff * SCALE) + 31'(C1_SCALED);
            f2_ff   <= 29'(vsum_ff * SCALE) + 29'(C2_SCALED);
            bfac_ff <= 30'(cov_ff * $signed({1'b0, SCALE2})) + $signed(30'(C2_SCALED));
         end
         ST_MUL3: begin
            num_ff <= afac_ff * bmag[28:0];
            den_ff <= f1_ff * f2_ff;
            neg_ff <= bfac_ff[29];
         end
         ST_QINIT: begin
            // saturate when the integer part is above one
            sat_ff  <= {1'b0, num_ff} >= {den_ff, 1'b0};
            q_ff    <= 17'(num_ff >= den_ff);
            rem_ff  <= (num_ff >= den_ff) ? num_ff - den_ff : num_ff;
            step_ff <= '0;
         end
         ST_QSTEP: begin
            step_ff <= step_ff + 1'b1;
            if (trial >= {1'b0, den_ff}) begin
               rem_ff <= 60'(trial - {1'b0, den_ff});
               q_ff   <= {q_ff[15:0], 1'b1};
            end else begin
               rem_ff <= trial[59:0];
               q_ff   <= {q_ff[15:0], 1'b0};
            end
         end
         ST_OUT: if (out_free) begin
            o_ssim_ff <= neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            o_ma_ff   <= ma_ff;
            o_mb_ff   <= mb_ff;
            o_va_ff   <= va_ff;
            o_vb_ff   <= vb_ff;
            o_cov_ff  <= cov_ff;
         end
         default: ;
      endcase
   end

   assign rsp.valid         = out_vld_ff;
   assign rsp.ssim_q16      = o_ssim_ff;
   assign rsp.mean_a        = o_ma_ff;
   assign rsp.mean_b        = o_mb_ff;
   assign rsp.variance_a    = o_va_ff;
   assign rsp.variance_b    = o_vb_ff;
   assign rsp.covariance_ab = o_cov_ff;
endmodule
